// ----- hdl/bdd_pkg.sv -----
// shared widths, codes and request/response types of the derivative unit
`timescale 1ns / 1ps
package bdd_pkg;

  localparam int SAMPLE_BITS = 32;
  localparam int FRAC_BITS   = 16;
  localparam int STEP_W      = 32;
  localparam int OUT_W       = 32;
  localparam int CFG_W       = 32;

  // x0 - 4*x1 + 3*x2 needs three extra bits plus sign headroom
  localparam int NUM_W       = SAMPLE_BITS + 4;
  // divisor is 2*dt at most
  localparam int DEN_W       = STEP_W + 1;
  localparam int DIVD_RAW    = NUM_W + FRAC_BITS;
  localparam int DIVD_W      = (DIVD_RAW > OUT_W) ? DIVD_RAW : OUT_W + 1;
  localparam int HI_W        = DIVD_W - OUT_W;
  localparam int CNT_W       = $clog2(OUT_W);

  localparam int IN_DATA_W   = ((SAMPLE_BITS + STEP_W + 7) / 8) * 8;

  // start phase codes
  localparam logic [1:0] PH_STEADY = 2'd0;
  localparam logic [1:0] PH_SECOND = 2'd1;
  localparam logic [1:0] PH_FIRST  = 2'd2;

  typedef struct packed {
    logic                    start;
    logic signed [NUM_W-1:0] num;
    logic [DEN_W-1:0]        den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [OUT_W-1:0] quo;
    logic             sat;
  } div_rsp_t;

endpackage

// ----- hdl/bdd_div.sv -----
// iterative restoring divider with fixed-point scaling and saturation
`timescale 1ns / 1ps
module bdd_div (
  input  logic              clk,
  input  logic              rst_n,
  input  bdd_pkg::div_req_t req,
  output bdd_pkg::div_rsp_t rsp
);
  import bdd_pkg::*;

  localparam int REM_W = DEN_W + 1;

  localparam logic [1:0] DV_IDLE = 2'd0;
  localparam logic [1:0] DV_CHK  = 2'd1;
  localparam logic [1:0] DV_RUN  = 2'd2;
  localparam logic [1:0] DV_FIN  = 2'd3;

  logic [1:0]        st_r, st_nxt;
  logic [DIVD_W-1:0] dvd_r;
  logic [DEN_W-1:0]  den_r;
  logic [DEN_W-1:0]  rem_r;
  logic [OUT_W-1:0]  quo_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              neg_r;
  logic              ovf_r;

  logic [NUM_W-1:0]  mag;
  logic [REM_W-1:0]  opa;
  logic [REM_W:0]    diff;
  logic              ge;
  logic [OUT_W-1:0]  lim;
  logic              sat;
  logic [OUT_W-1:0]  qsat;

  assign mag = req.num[NUM_W-1] ? NUM_W'(-req.num) : NUM_W'(req.num);

  // the one shared subtractor: overflow check first, then one quotient bit a cycle
  always_comb begin
    if (st_r == DV_CHK) begin
      opa = REM_W'(dvd_r[DIVD_W-1 -: HI_W]);
    end else begin
      opa = {rem_r, dvd_r[OUT_W-1]};
    end
  end

  assign diff = {1'b0, opa} - {2'b00, den_r};
  assign ge   = ~diff[REM_W];

  assign lim  = neg_r ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
  assign sat  = ovf_r | (quo_r > lim);
  assign qsat = sat ? lim : quo_r;

  assign rsp.done = (st_r == DV_FIN);
  assign rsp.quo  = neg_r ? OUT_W'(-qsat) : qsat;
  assign rsp.sat  = sat;

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      DV_IDLE: if (req.start) st_nxt = DV_CHK;
      DV_CHK:  st_nxt = ge ? DV_FIN : DV_RUN;
      DV_RUN:  if (cnt_r == CNT_W'(OUT_W - 1)) st_nxt = DV_FIN;
      DV_FIN:  st_nxt = DV_IDLE;
      default: st_nxt = DV_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= DV_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (st_r)
      DV_IDLE: begin
        if (req.start) begin
          dvd_r <= DIVD_W'(mag) << FRAC_BITS;
          den_r <= req.den;
          neg_r <= req.num[NUM_W-1];
          ovf_r <= 1'b0;
          cnt_r <= '0;
          quo_r <= '0;
        end
      end
      DV_CHK: begin
        // quotient of 2^OUT_W or more is clipped without iterating
        ovf_r <= ge;
        rem_r <= opa[DEN_W-1:0];
      end
      DV_RUN: begin
        rem_r <= ge ? diff[DEN_W-1:0] : opa[DEN_W-1:0];
        quo_r <= {quo_r[OUT_W-2:0], ge};
        dvd_r <= dvd_r << 1;
        cnt_r <= cnt_r + 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- hdl/backward_difference_derivative_unit.sv -----
// top level: sample history, start phase, numerator forming and result register
`timescale 1ns / 1ps
// a restart item's result (the initial value) is loaded into the result register on its
// input transfer; a derivative item goes through load, the overflow check and the quotient
// iterations of the shared divider, the iterations skipped when the check clips the quotient,
// then into the result register; either result then moves to the output register once it is
// free, and the next item is taken only after that, so one item is in flight at a time.
// reset (rst_n low, synchronous) clears history, start phase and initial value.
module backward_difference_derivative_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  // config write: initial_value
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bdd_pkg::CFG_W-1:0]      cfg_data,
  // in_tdata: sample [31:0], step [63:32]
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [bdd_pkg::IN_DATA_W-1:0]  in_tdata,
  // out_tdata: derivative [31:0]
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [bdd_pkg::OUT_W-1:0]      out_tdata,
  // out_tuser: saturated [0]
  output logic                           out_tuser
);
  import bdd_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_OUT  = 2'd2;

  logic [1:0]                    st_r, st_nxt;
  logic [1:0]                    phase_r;
  logic signed [SAMPLE_BITS-1:0] x0_r, x1_r, x2_r;
  logic [CFG_W-1:0]              init_r;
  logic [OUT_W-1:0]              res_r;
  logic                          res_sat_r;
  logic                          out_valid_r;
  logic [OUT_W-1:0]              out_data_r;
  logic                          out_sat_r;

  logic signed [SAMPLE_BITS-1:0] x;
  logic [STEP_W-1:0]             step;
  logic                          acc;
  logic                          restart;
  logic signed [NUM_W-1:0]       a0, a1, a2;
  div_req_t                      dreq;
  div_rsp_t                      drsp;
  logic                          out_free;

  assign x         = in_tdata[SAMPLE_BITS-1:0];
  assign step      = in_tdata[SAMPLE_BITS +: STEP_W];
  assign in_tready = (st_r == ST_IDLE);
  assign acc       = in_tvalid & in_tready;
  assign restart   = (step == '0);
  assign cfg_ready = 1'b1;
  assign out_free  = ~out_valid_r | out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_sat_r;

  // numerator operands: oldest, middle, newest after this item's history update
  always_comb begin
    if (phase_r == PH_SECOND) begin
      a0 = NUM_W'(x0_r);
      a1 = NUM_W'(x1_r);
    end else begin
      a0 = NUM_W'(x1_r);
      a1 = NUM_W'(x2_r);
    end
    a2 = NUM_W'(x);
  end

  always_comb begin
    dreq.start = acc & ~restart;
    if (phase_r == PH_FIRST) begin
      dreq.num = NUM_W'(x) - NUM_W'(x0_r);
      dreq.den = {1'b0, step};
    end else begin
      dreq.num = a0 - (a1 <<< 2) + a2 + (a2 <<< 1);
      dreq.den = {step, 1'b0};
    end
  end

  bdd_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dreq),
    .rsp   (drsp)
  );

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE: if (acc) st_nxt = restart ? ST_OUT : ST_DIV;
      ST_DIV:  if (drsp.done) st_nxt = ST_OUT;
      ST_OUT:  if (out_free) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      phase_r     <= PH_STEADY;
      x0_r        <= '0;
      x1_r        <= '0;
      x2_r        <= '0;
      init_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (cfg_valid) begin
        init_r <= cfg_data;
      end
      if (acc) begin
        if (restart) begin
          x0_r    <= x;
          phase_r <= PH_FIRST;
        end else if (phase_r == PH_FIRST) begin
          x1_r    <= x;
          phase_r <= PH_SECOND;
        end else if (phase_r == PH_SECOND) begin
          x2_r    <= x;
          phase_r <= PH_STEADY;
        end else begin
          x0_r    <= x1_r;
          x1_r    <= x2_r;
          x2_r    <= x;
          phase_r <= PH_STEADY;
        end
      end
      if (st_r == ST_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc && restart) begin
      res_r     <= init_r;
      res_sat_r <= 1'b0;
    end else if (st_r == ST_DIV && drsp.done) begin
      res_r     <= drsp.quo;
      res_sat_r <= drsp.sat;
    end
    // result transfer into the output register
    if (st_r == ST_OUT && out_free) begin
      out_data_r <= res_r;
      out_sat_r  <= res_sat_r;
    end
  end

endmodule

// ----- verif/tb.sv -----
// self-checking testbench of the backward-difference derivative unit
`timescale 1ns / 1ps
module tb;
  import bdd_pkg::*;

  typedef struct packed {
    logic [OUT_W-1:0] deriv;
    logic             sat;
  } deriv_result_t;

  // predicts the derivative stream and holds the results still owed by the block
  class deriv_scoreboard;
    logic [CFG_W-1:0] init_value;
    longint           hist_old;
    longint           hist_mid;
    longint           hist_new;
    logic [1:0]       phase;
    deriv_result_t    expected_derivs[$];
    int unsigned      mismatches;

    function new();
      init_value = '0;
      hist_old   = 0;
      hist_mid   = 0;
      hist_new   = 0;
      phase      = PH_STEADY;
      mismatches = 0;
    endfunction

    // num * 2^FRAC_BITS / den toward zero, clipped to the signed output range
    function deriv_result_t divide_q16(longint num, longint unsigned den);
      deriv_result_t   r;
      bit              neg;
      longint unsigned mag;
      longint unsigned lim;
      longint unsigned q;
      neg = num < 0;
      mag = neg ? -num : num;
      lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
      q = (mag << FRAC_BITS) / den;
      r.sat = q > lim;
      if (r.sat) q = lim;
      if (neg) q = -q;
      r.deriv = q[OUT_W-1:0];
      return r;
    endfunction

    function void predict_derivative(logic [SAMPLE_BITS-1:0] smp, logic [STEP_W-1:0] stp);
      longint        x;
      deriv_result_t r;
      x = longint'($signed(smp));
      if (stp == '0) begin
        hist_old = x;
        phase    = PH_FIRST;
        r.deriv  = init_value;
        r.sat    = 1'b0;
      end else if (phase == PH_FIRST) begin
        hist_mid = x;
        phase    = PH_SECOND;
        r = divide_q16(hist_mid - hist_old, stp);
      end else begin
        // second step only fills the newest slot, later ones shift the history
        if (phase == PH_SECOND) begin
          hist_new = x;
        end else begin
          hist_old = hist_mid;
          hist_mid = hist_new;
          hist_new = x;
        end
        phase = PH_STEADY;
        r = divide_q16(hist_old - 4 * hist_mid + 3 * hist_new, 2 * longint'(stp));
      end
      expected_derivs.push_back(r);
    endfunction

    function void check_derivative(logic [OUT_W-1:0] d, logic s);
      deriv_result_t e;
      if (expected_derivs.size() == 0) begin
        mismatches++;
        $display("%0t: result with none expected: derivative %h saturated %b", $time, d, s);
        return;
      end
      e = expected_derivs.pop_front();
      if (d !== e.deriv) begin
        mismatches++;
        $display("%0t: derivative expected %h actual %h", $time, e.deriv, d);
      end
      if (s !== e.sat) begin
        mismatches++;
        $display("%0t: saturated expected %b actual %b", $time, e.sat, s);
      end
    endfunction

    function int pending();
      return expected_derivs.size();
    endfunction
  endclass

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 cfg_valid  = 1'b0;
  logic                 cfg_ready;
  logic [CFG_W-1:0]     cfg_data   = '0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [IN_DATA_W-1:0] in_tdata   = '0;   // sample [31:0], step [63:32]
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [OUT_W-1:0]     out_tdata;         // derivative [31:0]
  logic                 out_tuser;         // saturated [0]
  logic                 steady_flow = 1'b0;

  deriv_scoreboard sb = new();

  backward_difference_derivative_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_tready <= steady_flow || ($urandom_range(99) >= 21);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_derivative(out_tdata, out_tuser);
  end

  task automatic push_item(input logic [SAMPLE_BITS-1:0] smp, input logic [STEP_W-1:0] stp);
    if (!steady_flow) begin
      while ($urandom_range(99) < 21) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {stp, smp};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.predict_derivative(smp, stp);
  endtask

  // stop sending and wait until every owed result has come back
  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_initial_value(input logic [CFG_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.init_value = v;
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [SAMPLE_BITS-1:0] rand_sample();
    case ($urandom_range(9))
      0:       return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      1, 2:    return $urandom;
      default: return 32'($urandom_range(32'h0020_0000)) - 32'h0010_0000;
    endcase
  endfunction

  function automatic logic [STEP_W-1:0] rand_step();
    case ($urandom_range(9))
      0:       return $urandom_range(16, 1);
      1, 2:    return $urandom;
      default: return $urandom_range(32'h0010_0000, 32'h0000_1000);
    endcase
  endfunction

  // mostly restart followed by a run of steps, now and then a stray item
  task automatic run_sequences(input int n);
    int sent;
    int len;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(99) < 85) begin
        push_item(rand_sample(), '0);
        len = $urandom_range(12, 1);
        repeat (len) push_item(rand_sample(), rand_step());
        sent += len + 1;
      end else begin
        push_item(rand_sample(), ($urandom_range(3) == 0) ? 32'h0 : rand_step());
        sent++;
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // steady mode on the cleared history before any restart
    push_item(32'h7FFF_FFFF, 32'h0000_0001);
    push_item(32'h8000_0000, 32'hFFFF_FFFF);
    drain();
    write_initial_value(32'h7FFF_FFFF);
    push_item(32'h8000_0000, 32'h0);
    push_item(32'h7FFF_FFFF, 32'h0000_0001);
    push_item(32'h0000_0000, 32'h0001_0000);
    push_item(32'h0001_2345, 32'hFFFF_FFFF);
    push_item(32'h8000_0000, 32'h0000_0001);
    // quotient lands exactly on the most negative value, no clipping
    push_item(32'h0000_0000, 32'h0);
    push_item(32'hFFFF_8000, 32'h0000_0001);
    // one lsb past the positive limit
    push_item(32'h0000_0000, 32'h0);
    push_item(32'h0000_8000, 32'h0000_0001);
    drain();
    write_initial_value(32'h8000_0000);
    // back-to-back restarts, then a clean start phase
    push_item(32'h0000_0005, 32'h0);
    push_item(32'h0000_0006, 32'h0);
    push_item(32'h0001_0000, 32'h0001_0000);
    push_item(32'h0003_0000, 32'h0001_0000);
    push_item(32'h0006_0000, 32'h0000_8000);
    push_item(32'hFFFF_FFFF, 32'h8000_0000);

    for (int ph = 0; ph < 5; ph++) begin
      drain();
      case (ph)
        0:       write_initial_value(32'hFFFF_FFFF);
        1:       write_initial_value(32'h0000_0000);
        4:       write_initial_value(32'h7FFF_FFFF);
        default: write_initial_value($urandom);
      endcase
      steady_flow <= (ph == 3);
      run_sequences(335);
    end

    drain();
    repeat (40) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ----- files.f -----
hdl/bdd_pkg.sv
hdl/bdd_div.sv
hdl/backward_difference_derivative_unit.sv
verif/tb.sv
